>>> sv/scaled_elementwise_add_core_macros.svh
`ifndef SCALED_ELEMENTWISE_ADD_CORE_MACROS_SVH
`define SCALED_ELEMENTWISE_ADD_CORE_MACROS_SVH

// same-cycle implication, sampled on clk, off during rst
`define SEA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SEA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> sv/sea_pkg.sv
`default_nettype none

package sea_pkg;

  typedef enum logic [1:0] {
    TY_F32 = 2'd0,
    TY_F16 = 2'd1,
    TY_I32 = 2'd2,
    TY_BAD = 2'd3
  } elem_type_t;

  localparam logic [0:0] CFG_TYPE  = 1'b0;
  localparam logic [0:0] CFG_ALPHA = 1'b1;

  localparam logic [31:0] ALPHA_RESET = 32'h3F80_0000;
  localparam logic [31:0] QNAN32      = 32'h7FC0_0000;
  localparam logic [15:0] QNAN16      = 16'h7E00;

  localparam int NSTAGE = 9;

  typedef struct packed {
    elem_type_t ty;
    logic       last;
  } tag_t;

  function automatic logic [5:0] lzc50(input logic [49:0] m);
    logic [5:0] n;
    logic       found;
    n     = 6'd0;
    found = 1'b0;
    for (int i = 49; i >= 0; i--) begin
      if (!found) begin
        if (m[i]) found = 1'b1;
        else n = n + 6'd1;
      end
    end
    return n;
  endfunction

  function automatic logic [31:0] half_to_single(input logic [15:0] h);
    logic [4:0]  ex;
    logic [9:0]  man;
    logic [3:0]  lz;
    logic        found;
    logic [10:0] shifted;
    logic [7:0]  e;
    logic [31:0] r;
    ex    = h[14:10];
    man   = h[9:0];
    lz    = 4'd0;
    found = 1'b0;
    for (int i = 9; i >= 0; i--) begin
      if (!found) begin
        if (man[i]) found = 1'b1;
        else lz = lz + 4'd1;
      end
    end
    shifted = {1'b0, man} << (lz + 4'd1);
    e       = 8'd112 - {4'd0, lz};
    if (ex == 5'd0) begin
      if (man == 10'd0) r = {h[15], 31'd0};
      else r = {h[15], e, shifted[9:0], 13'd0};
    end else if (ex == 5'h1F) begin
      r = {h[15], 8'hFF, man, 13'd0};
    end else begin
      r = {h[15], {3'd0, ex} + 8'd112, man, 13'd0};
    end
    return r;
  endfunction

  function automatic logic [15:0] single_to_half(input logic [31:0] f);
    logic              s;
    logic [7:0]        ex;
    logic [22:0]       man;
    logic signed [9:0] e;
    logic [23:0]       m;
    logic [4:0]        sh;
    logic [23:0]       hs;
    logic [23:0]       rem;
    logic [23:0]       halfv;
    logic [14:0]       h;
    logic [15:0]       r;
    s     = f[31];
    ex    = f[30:23];
    man   = f[22:0];
    e     = $signed({2'b00, ex}) - 10'sd112;
    m     = {1'b1, man};
    sh    = 5'(10'sd14 - e);
    hs    = m >> sh;
    rem   = m & ~(24'hFF_FFFF << sh);
    halfv = 24'd1 << (sh - 5'd1);
    h     = {e[4:0], man[22:13]};
    if (ex == 8'hFF) begin
      r = (man != 23'd0) ? QNAN16 : {s, 15'h7C00};
    end else if (e >= 10'sd31) begin
      r = {s, 15'h7C00};
    end else if (e <= 10'sd0) begin
      if (e < -10'sd10) begin
        r = {s, 15'd0};
      end else begin
        if (rem > halfv || (rem == halfv && hs[0])) hs = hs + 24'd1;
        r = {s, hs[14:0]};
      end
    end else begin
      if (man[12:0] > 13'h1000 || (man[12:0] == 13'h1000 && h[0])) h = h + 15'd1;
      r = {s, h};
    end
    return r;
  endfunction

  function automatic logic [31:0] alpha_to_int(input logic [31:0] a);
    logic [7:0]  ex;
    logic [23:0] m;
    logic [31:0] mag;
    logic [31:0] r;
    ex = a[30:23];
    m  = {1'b1, a[22:0]};
    if (ex >= 8'd150) mag = {8'd0, m} << (ex - 8'd150);
    else mag = {8'd0, m >> (8'd150 - ex)};
    if (ex == 8'hFF && a[22:0] != 23'd0) r = 32'd0;
    else if (ex >= 8'd158) r = a[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    else if (ex < 8'd127) r = 32'd0;
    else r = a[31] ? (32'd0 - mag) : mag;
    return r;
  endfunction

endpackage

`default_nettype wire

>>> sv/sea_in_if.sv
`default_nettype none

interface sea_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] x_bits;
  logic [31:0] y_bits;
  logic        last_element;

  modport source (output valid, x_bits, y_bits, last_element, input ready);
  modport sink   (input valid, x_bits, y_bits, last_element, output ready);
endinterface

`default_nettype wire

>>> sv/sea_out_if.sv
`default_nettype none

interface sea_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] sum_bits;
  logic        type_error;
  logic        last_result;

  modport source (output valid, sum_bits, type_error, last_result, input ready);
  modport sink   (input valid, sum_bits, type_error, last_result, output ready);
endinterface

`default_nettype wire

>>> sv/sea_cfg_if.sv
`default_nettype none

interface sea_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

>>> sv/sea_norm_round.sv
`default_nettype none

// two stages: normalize, then round to single (RNE, subnormals kept)
module sea_norm_round (
  input  wire logic               clk,
  input  wire logic               en_norm,
  input  wire logic               en_round,
  input  wire logic               sgn,
  input  wire logic [49:0]        mag,
  input  wire logic signed [11:0] expo,
  output      logic [31:0]        res
);
  import sea_pkg::*;

  logic [5:0]         lz;
  logic               n_sgn;
  logic [49:0]        n_mn;
  logic signed [11:0] n_be;

  logic signed [11:0] amt;
  logic [5:0]         amt_c;
  logic [49:0]        sh;
  logic               lost;
  logic [7:0]         ef;
  logic [30:0]        q;
  logic               rnd;
  logic [31:0]        res_next;

  assign lz = lzc50(mag);

  always_ff @(posedge clk) begin
    if (en_norm) begin
      n_sgn <= sgn;
      n_mn  <= mag << lz;
      n_be  <= expo + 12'sd176 - $signed({6'd0, lz});
    end
  end

  always_comb begin
    amt   = 12'sd1 - n_be;
    if (n_be >= 12'sd1) amt_c = 6'd0;
    else if (amt > 12'sd50) amt_c = 6'd50;
    else amt_c = amt[5:0];
    sh    = n_mn >> amt_c;
    lost  = |(n_mn & ~({50{1'b1}} << amt_c));
    ef    = (n_be >= 12'sd1) ? n_be[7:0] : 8'd0;
    q     = {ef, sh[48:26]};
    rnd   = sh[25] & ((|sh[24:0]) | lost | q[0]);
    if (n_be >= 12'sd255) res_next = {n_sgn, 8'hFF, 23'd0};
    else res_next = {n_sgn, q + {30'd0, rnd}};
  end

  always_ff @(posedge clk) begin
    if (en_round) res <= res_next;
  end

endmodule

`default_nettype wire

>>> sv/scaled_elementwise_add_core.sv
// Channel | Dir | Payload                                  | Handshake
// elem    | in  | x_bits, y_bits, last_element             | valid/ready
// res     | out | sum_bits, type_error, last_result        | valid/ready
// cfg     | in  | index, data (0 element_type, 1 alpha)    | valid/ready
//
// Nine register stages: operand prep, multiply, product normalize/round,
// align, add, sum normalize/round, format select into the output register.
// One transaction per cycle while res.ready is high; the 32x32 multiplier stage
// is shared by the float and int32 paths.
// rst (synchronous) clears the valid bits and the config registers.
// A stall holds only the stages that are full; bubbles keep draining.
`default_nettype none

`include "scaled_elementwise_add_core_macros.svh"

module scaled_elementwise_add_core (
  input  wire logic  clk,
  input  wire logic  rst,
  sea_in_if.sink     elem,
  sea_out_if.source  res,
  sea_cfg_if.sink    cfg
);
  import sea_pkg::*;

  elem_type_t  ety;
  logic [31:0] alpha;

  logic [NSTAGE:1]   v;
  logic [NSTAGE+1:1] en;

  // stage 1
  logic [31:0] xs_c, ys_c;
  logic [7:0]  ea_c, ey_c, eae_c, eye_c;
  logic        a_nan, a_inf, a_zero, y_nan, y_inf, y_zero;
  tag_t        tag1, tag2, tag3, tag4, tag5, tag6, tag7, tag8;
  logic [31:0] s1_opa, s1_opb, s1_x;
  logic signed [11:0] s1_pe, s2_pe;
  logic        s1_pnan, s1_pinf, s1_pzero, s1_psign;

  // stage 2
  logic [63:0] s2_prod;
  logic [31:0] s2_x;
  logic        s2_pnan, s2_pinf, s2_pzero, s2_psign;

  // stages 3, 4
  logic [31:0] s3_x, s4_x, s3_isum, s4_isum, s5_isum, s6_isum, s7_isum, s8_isum;
  logic        s3_pnan, s3_pinf, s3_pzero, s3_psign;
  logic        s4_pnan, s4_pinf, s4_pzero, s4_psign;
  logic [31:0] prod_rnd;

  // stage 5
  logic [31:0] p_c, big_c, sml_c;
  logic        x_nan, x_inf, p_nan, p_inf;
  logic [7:0]  eb_c, es_c;
  logic [23:0] mb_c, ms_c;
  logic [7:0]  d_c;
  logic [5:0]  dd_c;
  logic [49:0] bf_c, bs_c;
  logic [49:0] s5_a, s5_b;
  logic [7:0]  s5_ea;
  logic        s5_sub, s5_sgn, s5_nan, s5_inf, s5_infs, s5_zs;

  // stage 6..8
  logic [49:0] s6_sum;
  logic signed [11:0] s6_e;
  logic        s6_sgn, s6_nan, s6_inf, s6_infs, s6_zs;
  logic        s7_nan, s7_inf, s7_infs, s7_zs, s7_zero;
  logic        s8_nan, s8_inf, s8_infs, s8_zs, s8_zero;
  logic [31:0] sum_rnd;

  // stage 9
  logic [31:0] r_c, out_c;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      ety   <= TY_F32;
      alpha <= ALPHA_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        CFG_TYPE:  ety   <= elem_type_t'(cfg.data[1:0]);
        CFG_ALPHA: alpha <= cfg.data;
        default:   ;
      endcase
    end
  end

  always_comb begin
    en[NSTAGE+1] = res.ready;
    for (int k = NSTAGE; k >= 1; k--) en[k] = !v[k] || en[k+1];
  end

  assign elem.ready = en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (en[1]) v[1] <= elem.valid;
      for (int k = 2; k <= NSTAGE; k++) begin
        if (en[k]) v[k] <= v[k-1];
      end
    end
  end

  // stage 1: widen, unpack, pick multiplier operands
  always_comb begin
    xs_c   = (ety == TY_F16) ? half_to_single(elem.x_bits[15:0]) : elem.x_bits;
    ys_c   = (ety == TY_F16) ? half_to_single(elem.y_bits[15:0]) : elem.y_bits;
    ea_c   = alpha[30:23];
    ey_c   = ys_c[30:23];
    eae_c  = (ea_c == 8'd0) ? 8'd1 : ea_c;
    eye_c  = (ey_c == 8'd0) ? 8'd1 : ey_c;
    a_nan  = (ea_c == 8'hFF) && (alpha[22:0] != 23'd0);
    a_inf  = (ea_c == 8'hFF) && (alpha[22:0] == 23'd0);
    a_zero = (ea_c == 8'd0) && (alpha[22:0] == 23'd0);
    y_nan  = (ey_c == 8'hFF) && (ys_c[22:0] != 23'd0);
    y_inf  = (ey_c == 8'hFF) && (ys_c[22:0] == 23'd0);
    y_zero = (ey_c == 8'd0) && (ys_c[22:0] == 23'd0);
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      tag1     <= '{ty: ety, last: elem.last_element};
      s1_x     <= (ety == TY_I32) ? elem.x_bits : xs_c;
      s1_opa   <= (ety == TY_I32) ? alpha_to_int(alpha)
                                  : {8'd0, (ea_c != 8'd0), alpha[22:0]};
      s1_opb   <= (ety == TY_I32) ? elem.y_bits
                                  : {8'd0, (ey_c != 8'd0), ys_c[22:0]};
      s1_pe    <= $signed({4'd0, eae_c}) + $signed({4'd0, eye_c}) - 12'sd300;
      s1_pnan  <= a_nan || y_nan || (a_inf && y_zero) || (a_zero && y_inf);
      s1_pinf  <= a_inf || y_inf;
      s1_pzero <= a_zero || y_zero;
      s1_psign <= alpha[31] ^ ys_c[31];
    end
  end

  // stage 2: multiply
  always_ff @(posedge clk) begin
    if (en[2]) begin
      tag2     <= tag1;
      s2_prod  <= s1_opa * s1_opb;
      s2_pe    <= s1_pe;
      s2_x     <= s1_x;
      s2_pnan  <= s1_pnan;
      s2_pinf  <= s1_pinf;
      s2_pzero <= s1_pzero;
      s2_psign <= s1_psign;
    end
  end

  // stages 3, 4: product rounding
  sea_norm_round u_prod_rnd (
    .clk      (clk),
    .en_norm  (en[3]),
    .en_round (en[4]),
    .sgn      (s2_psign),
    .mag      ({2'b00, s2_prod[47:0]}),
    .expo     (s2_pe),
    .res      (prod_rnd)
  );

  always_ff @(posedge clk) begin
    if (en[3]) begin
      tag3     <= tag2;
      s3_x     <= s2_x;
      s3_isum  <= s2_x + s2_prod[31:0];
      s3_pnan  <= s2_pnan;
      s3_pinf  <= s2_pinf;
      s3_pzero <= s2_pzero;
      s3_psign <= s2_psign;
    end
    if (en[4]) begin
      tag4     <= tag3;
      s4_x     <= s3_x;
      s4_isum  <= s3_isum;
      s4_pnan  <= s3_pnan;
      s4_pinf  <= s3_pinf;
      s4_pzero <= s3_pzero;
      s4_psign <= s3_psign;
    end
  end

  // stage 5: align
  always_comb begin
    if (s4_pnan) p_c = QNAN32;
    else if (s4_pinf) p_c = {s4_psign, 8'hFF, 23'd0};
    else if (s4_pzero) p_c = {s4_psign, 31'd0};
    else p_c = prod_rnd;
    x_nan = (s4_x[30:23] == 8'hFF) && (s4_x[22:0] != 23'd0);
    x_inf = (s4_x[30:23] == 8'hFF) && (s4_x[22:0] == 23'd0);
    p_nan = (p_c[30:23] == 8'hFF) && (p_c[22:0] != 23'd0);
    p_inf = (p_c[30:23] == 8'hFF) && (p_c[22:0] == 23'd0);
    if (s4_x[30:0] >= p_c[30:0]) begin
      big_c = s4_x;
      sml_c = p_c;
    end else begin
      big_c = p_c;
      sml_c = s4_x;
    end
    eb_c = (big_c[30:23] == 8'd0) ? 8'd1 : big_c[30:23];
    es_c = (sml_c[30:23] == 8'd0) ? 8'd1 : sml_c[30:23];
    mb_c = {(big_c[30:23] != 8'd0), big_c[22:0]};
    ms_c = {(sml_c[30:23] != 8'd0), sml_c[22:0]};
    d_c  = eb_c - es_c;
    dd_c = (d_c > 8'd50) ? 6'd50 : d_c[5:0];
    bf_c = {1'b0, ms_c, 25'd0};
    bs_c = bf_c >> dd_c;
    bs_c[0] = bs_c[0] | (|(bf_c & ~({50{1'b1}} << dd_c)));
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      tag5    <= tag4;
      s5_isum <= s4_isum;
      s5_a    <= {1'b0, mb_c, 25'd0};
      s5_b    <= bs_c;
      s5_ea   <= eb_c;
      s5_sub  <= big_c[31] ^ sml_c[31];
      s5_sgn  <= big_c[31];
      s5_nan  <= x_nan || p_nan || (x_inf && p_inf && (s4_x[31] != p_c[31]));
      s5_inf  <= x_inf || p_inf;
      s5_infs <= x_inf ? s4_x[31] : p_c[31];
      s5_zs   <= s4_x[31] & p_c[31];
    end
  end

  // stage 6: add
  always_ff @(posedge clk) begin
    if (en[6]) begin
      tag6    <= tag5;
      s6_isum <= s5_isum;
      s6_sum  <= s5_sub ? (s5_a - s5_b) : (s5_a + s5_b);
      s6_e    <= $signed({4'd0, s5_ea}) - 12'sd175;
      s6_sgn  <= s5_sgn;
      s6_nan  <= s5_nan;
      s6_inf  <= s5_inf;
      s6_infs <= s5_infs;
      s6_zs   <= s5_zs;
    end
  end

  // stages 7, 8: sum rounding
  sea_norm_round u_sum_rnd (
    .clk      (clk),
    .en_norm  (en[7]),
    .en_round (en[8]),
    .sgn      (s6_sgn),
    .mag      (s6_sum),
    .expo     (s6_e),
    .res      (sum_rnd)
  );

  always_ff @(posedge clk) begin
    if (en[7]) begin
      tag7    <= tag6;
      s7_isum <= s6_isum;
      s7_nan  <= s6_nan;
      s7_inf  <= s6_inf;
      s7_infs <= s6_infs;
      s7_zs   <= s6_zs;
      s7_zero <= (s6_sum == 50'd0);
    end
    if (en[8]) begin
      tag8    <= tag7;
      s8_isum <= s7_isum;
      s8_nan  <= s7_nan;
      s8_inf  <= s7_inf;
      s8_infs <= s7_infs;
      s8_zs   <= s7_zs;
      s8_zero <= s7_zero;
    end
  end

  // stage 9: format select into output register
  always_comb begin
    if (s8_nan) r_c = QNAN32;
    else if (s8_inf) r_c = {s8_infs, 8'hFF, 23'd0};
    else if (s8_zero) r_c = {s8_zs, 31'd0};
    else r_c = sum_rnd;
    unique case (tag8.ty)
      TY_F32:  out_c = r_c;
      TY_F16:  out_c = {16'd0, single_to_half(r_c)};
      TY_I32:  out_c = s8_isum;
      default: out_c = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en[9]) begin
      res.sum_bits    <= out_c;
      res.type_error  <= (tag8.ty == TY_BAD);
      res.last_result <= tag8.last;
    end
  end

  assign res.valid = v[NSTAGE];

  `SEA_ASSERT_NOW(a_err_zero, res.valid && res.type_error, res.sum_bits == 32'd0, "error with nonzero sum")
  `SEA_ASSERT_NOW(a_idle_ready, !res.valid, elem.ready, "input blocked with empty output")
  `SEA_ASSERT_NEXT(a_stall_hold, v[8] && v[9] && !res.ready, v[8], "stage lost while stalled")
  `SEA_ASSERT_NEXT(a_err_flag, v[8] && en[9] && tag8.ty == TY_BAD, res.type_error, "type error not flagged")

endmodule

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import sea_pkg::*;

  typedef struct {
    logic [31:0] sum;
    logic        err;
    logic        last;
  } sum_exp_t;

  class axpy_scoreboard;
    elem_type_t  ty = TY_F32;
    logic [31:0] alpha = ALPHA_RESET;
    sum_exp_t    expected_sums[$];
    int          errors = 0;

    function void set_reg(logic [0:0] idx, logic [31:0] data);
      if (idx == CFG_TYPE) ty = elem_type_t'(data[1:0]);
      else alpha = data;
    endfunction

    function bit is_nan32(logic [31:0] b);
      return b[30:23] == 8'hFF && b[22:0] != 23'd0;
    endfunction

    // value = mag * 2^ex, rounded to nearest even into single or half
    function logic [31:0] fp_round(bit s, logic [127:0] mag, int ex, bit hp);
      int mb, emn, bias, emax, p, q, sh, biased;
      logic [127:0] keep, rem, halfw;
      mb = hp ? 10 : 23;
      emn = hp ? -24 : -149;
      bias = hp ? 15 : 127;
      emax = hp ? 31 : 255;
      if (mag == 128'd0) return hp ? {16'd0, s, 15'd0} : {s, 31'd0};
      p = 0;
      for (int i = 0; i < 128; i++) if (mag[i]) p = i;
      q = p + ex - mb;
      if (q < emn) q = emn;
      if (q > ex) begin
        sh = q - ex;
        if (sh > p + 1) begin
          keep = 128'd0;
        end else begin
          keep = mag >> sh;
          rem = mag & ((128'd1 << sh) - 128'd1);
          halfw = 128'd1 << (sh - 1);
          if (rem > halfw || (rem == halfw && keep[0])) keep = keep + 128'd1;
        end
      end else begin
        keep = mag << (ex - q);
      end
      if (keep == (128'd1 << (mb + 1))) begin
        keep = keep >> 1;
        q++;
      end
      if (keep < (128'd1 << mb)) return hp ? {16'd0, s, keep[14:0]} : {s, keep[30:0]};
      biased = q + mb + bias;
      if (biased >= emax) return hp ? {16'd0, s, 15'h7C00} : {s, 31'h7F80_0000};
      return hp ? {16'd0, s, 5'(biased), keep[9:0]} : {s, 8'(biased), keep[22:0]};
    endfunction

    function void unpack32(logic [31:0] b, output logic [23:0] m, output int e);
      if (b[30:23] == 8'd0) begin
        m = {1'b0, b[22:0]};
        e = -149;
      end else begin
        m = {1'b1, b[22:0]};
        e = int'(b[30:23]) - 150;
      end
    endfunction

    function logic [31:0] mul32(logic [31:0] a, logic [31:0] b);
      logic [23:0] ma, mb;
      int ea, eb;
      bit s, ainf, binf;
      s = a[31] ^ b[31];
      ainf = a[30:0] == 31'h7F80_0000;
      binf = b[30:0] == 31'h7F80_0000;
      if (is_nan32(a) || is_nan32(b)) return QNAN32;
      if ((ainf && b[30:0] == 31'd0) || (binf && a[30:0] == 31'd0)) return QNAN32;
      if (ainf || binf) return {s, 31'h7F80_0000};
      unpack32(a, ma, ea);
      unpack32(b, mb, eb);
      return fp_round(s, {104'd0, ma} * {104'd0, mb}, ea + eb, 1'b0);
    endfunction

    function logic [31:0] add32(logic [31:0] a, logic [31:0] b);
      logic [23:0] ma, mb;
      logic [127:0] wa, wb, mag;
      int ea, eb, emin;
      bit s, ainf, binf;
      ainf = a[30:0] == 31'h7F80_0000;
      binf = b[30:0] == 31'h7F80_0000;
      if (is_nan32(a) || is_nan32(b)) return QNAN32;
      if (ainf && binf && a[31] != b[31]) return QNAN32;
      if (ainf) return a;
      if (binf) return b;
      if (a[30:0] == 31'd0 && b[30:0] == 31'd0) return {a[31] & b[31], 31'd0};
      unpack32(a, ma, ea);
      unpack32(b, mb, eb);
      // far-apart operands: the small one only matters as a sticky bit
      if (ea - eb > 60) begin
        mb = {23'd0, mb != 24'd0};
        eb = ea - 60;
      end else if (eb - ea > 60) begin
        ma = {23'd0, ma != 24'd0};
        ea = eb - 60;
      end
      emin = (ea < eb) ? ea : eb;
      wa = {104'd0, ma} << (ea - emin);
      wb = {104'd0, mb} << (eb - emin);
      if (a[31] == b[31]) begin
        mag = wa + wb;
        s = a[31];
      end else if (wa >= wb) begin
        mag = wa - wb;
        s = a[31];
      end else begin
        mag = wb - wa;
        s = b[31];
      end
      if (mag == 128'd0) s = 1'b0;
      return fp_round(s, mag, emin, 1'b0);
    endfunction

    function logic [31:0] widen_half(logic [15:0] h);
      if (h[14:10] == 5'h1F) return {h[15], 8'hFF, h[9:0], 13'd0};
      if (h[14:10] == 5'd0) return fp_round(h[15], {118'd0, h[9:0]}, -24, 1'b0);
      return fp_round(h[15], {117'd0, 1'b1, h[9:0]}, int'(h[14:10]) - 25, 1'b0);
    endfunction

    function logic [15:0] narrow_to_half(logic [31:0] f);
      logic [23:0] m;
      logic [31:0] r;
      int e;
      if (is_nan32(f)) return QNAN16;
      if (f[30:0] == 31'h7F80_0000) return {f[31], 15'h7C00};
      unpack32(f, m, e);
      r = fp_round(f[31], {104'd0, m}, e, 1'b1);
      return r[15:0];
    endfunction

    function logic [31:0] scaled_sum(logic [31:0] x, logic [31:0] y);
      logic [31:0] r;
      r = add32(x, mul32(alpha, y));
      return is_nan32(r) ? QNAN32 : r;
    endfunction

    function logic [31:0] int_scale();
      logic [7:0] ex;
      logic [31:0] m, mag;
      ex = alpha[30:23];
      m = {8'd0, 1'b1, alpha[22:0]};
      if (is_nan32(alpha)) return 32'd0;
      if (ex >= 8'd158) return alpha[31] ? 32'h8000_0000 : 32'h7FFF_FFFF;
      if (ex < 8'd127) return 32'd0;
      mag = (ex >= 8'd150) ? (m << (ex - 8'd150)) : (m >> (8'd150 - ex));
      return alpha[31] ? 32'd0 - mag : mag;
    endfunction

    function void note_element(logic [31:0] x, logic [31:0] y, logic last);
      sum_exp_t e;
      e.sum = 32'd0;
      e.err = 1'b0;
      e.last = last;
      case (ty)
        TY_F32: e.sum = scaled_sum(x, y);
        TY_F16: e.sum = {16'd0, narrow_to_half(scaled_sum(widen_half(x[15:0]),
                                                          widen_half(y[15:0])))};
        TY_I32: e.sum = x + int_scale() * y;
        default: e.err = 1'b1;
      endcase
      expected_sums.push_back(e);
    endfunction

    function void check_sum(logic [31:0] sum, logic err, logic last);
      sum_exp_t e;
      if (expected_sums.size() == 0) begin
        $display("%0t unexpected transaction sum %h err %b last %b", $time, sum, err, last);
        errors++;
        return;
      end
      e = expected_sums.pop_front();
      if (sum !== e.sum) begin
        $display("%0t sum_bits expected %h actual %h", $time, e.sum, sum);
        errors++;
      end
      if (err !== e.err) begin
        $display("%0t type_error expected %b actual %b", $time, e.err, err);
        errors++;
      end
      if (last !== e.last) begin
        $display("%0t last_result expected %b actual %b", $time, e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;
  bit   calm = 1'b0;

  sea_in_if  elem();
  sea_out_if res();
  sea_cfg_if cfg();

  axpy_scoreboard sb = new();

  scaled_elementwise_add_core u_top (
    .clk  (clk),
    .rst  (rst),
    .elem (elem),
    .res  (res),
    .cfg  (cfg)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst) res.ready <= 1'b0;
    else res.ready <= calm || ($urandom_range(99) >= 20);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (elem.valid && elem.ready) sb.note_element(elem.x_bits, elem.y_bits, elem.last_element);
      if (res.valid && res.ready) sb.check_sum(res.sum_bits, res.type_error, res.last_result);
    end
  end

  task automatic send_elem(logic [31:0] x, logic [31:0] y, logic last);
    if (!calm) begin
      while ($urandom_range(99) < 20) begin
        elem.valid <= 1'b0;
        @(posedge clk);
      end
    end
    elem.valid <= 1'b1;
    elem.x_bits <= x;
    elem.y_bits <= y;
    elem.last_element <= last;
    do @(posedge clk); while (!elem.ready);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [31:0] data);
    elem.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_sums.size() != 0) @(posedge clk);
    repeat (NSTAGE + 3) @(posedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data <= data;
    do @(posedge clk); while (!cfg.ready);
    cfg.valid <= 1'b0;
    sb.set_reg(idx, data);
  endtask

  function automatic logic [31:0] pick_operand(elem_type_t ty);
    logic [31:0] specials[8] = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                                 32'h7FC0_0001, 32'h7F7F_FFFF, 32'h0000_0001, 32'h0080_0000};
    logic [15:0] hspec[8] = '{16'h0000, 16'h8000, 16'h7C00, 16'hFC00,
                              16'h7D01, 16'h7BFF, 16'h0001, 16'h0400};
    logic [31:0] r;
    r = $urandom;
    case ($urandom_range(9))
      4: r = (ty == TY_F16) ? {r[31:16], hspec[$urandom_range(7)]} : specials[$urandom_range(7)];
      5, 6: r = (ty == TY_F16) ? {r[31:16], r[15], 5'(8 + $urandom_range(14)), r[9:0]}
                               : {r[31], 8'(116 + $urandom_range(20)), r[22:0]};
      7: r = (ty == TY_F16) ? {r[31:16], r[15], 5'd0, r[9:0]} : {r[31], 8'd0, r[22:0]};
      8: r = 32'($urandom_range(40)) - 32'd20;
      default: ;
    endcase
    return r;
  endfunction

  initial begin
    logic [31:0] x, y, p;
    elem_type_t  tys[17] = '{TY_F32, TY_F32, TY_F32, TY_F32, TY_F32, TY_F32,
                             TY_F16, TY_F16, TY_F16, TY_F16,
                             TY_I32, TY_I32, TY_I32, TY_I32, TY_I32, TY_I32, TY_BAD};
    logic [31:0] alphas[17] = '{32'h3F80_0000, 32'h0, 32'h0, 32'h7F80_0000, 32'hFFFF_FFFF,
                                32'h0000_0001, 32'h3F80_0000, 32'hBF00_0000, 32'h0,
                                32'h477F_E000, 32'h4040_0000, 32'h4F00_0000, 32'hCF00_0000,
                                32'hC0E0_0000, 32'h7FC0_0000, 32'h0, 32'h0};
    rst = 1'b1;
    elem.valid = 1'b0;
    elem.x_bits = 32'd0;
    elem.y_bits = 32'd0;
    elem.last_element = 1'b0;
    cfg.valid = 1'b0;
    cfg.index = CFG_TYPE;
    cfg.data = 32'd0;
    res.ready = 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset settings: float32, alpha 1.0
    send_elem(32'h0000_0000, 32'h0000_0000, 1'b0);
    send_elem(32'h8000_0000, 32'h8000_0000, 1'b0);
    send_elem(32'h7F80_0000, 32'hFF80_0000, 1'b0);
    send_elem(32'h7FFF_FFFF, 32'h0000_0000, 1'b0);
    send_elem(32'h7F7F_FFFF, 32'h7F7F_FFFF, 1'b1);
    send_elem(32'h0000_0001, 32'h0000_0001, 1'b0);
    send_elem(32'h0000_0001, 32'h8000_0001, 1'b0);
    send_elem(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_elem(32'h3F80_0000, 32'hBF80_0000, 1'b0);
    send_elem(32'h4B80_0000, 32'h3F80_0001, 1'b1);
    send_elem(32'h3380_0000, 32'h3F80_0000, 1'b0);
    write_reg(CFG_TYPE, {30'd0, TY_F16});
    send_elem(32'h0000_7BFF, 32'h0000_7BFF, 1'b0);
    send_elem(32'h0000_0001, 32'h0000_0001, 1'b0);
    send_elem(32'hFFFF_0001, 32'hABCD_8001, 1'b0);
    send_elem(32'h0000_7C00, 32'h0000_FC00, 1'b0);
    send_elem(32'h1234_7E01, 32'h0000_3C00, 1'b0);
    send_elem(32'h0000_3C00, 32'h0000_1000, 1'b0);
    send_elem(32'h0000_FFFF, 32'hFFFF_FFFF, 1'b1);
    send_elem(32'h0000_8000, 32'h0000_8000, 1'b0);
    send_elem(32'h0000_0400, 32'h0000_83FF, 1'b1);

    for (int ph = 0; ph < 17; ph++) begin
      write_reg(CFG_TYPE, {30'd0, tys[ph]});
      write_reg(CFG_ALPHA, (ph == 1 || ph == 8 || ph >= 15) ? $urandom : alphas[ph]);
      calm = (ph == 3);
      for (int n = 0; n < 100; n++) begin
        x = pick_operand(tys[ph]);
        y = pick_operand(tys[ph]);
        if ($urandom_range(99) < 15) begin
          if (tys[ph] == TY_F32) begin
            p = sb.mul32(sb.alpha, y);
            x = {~p[31], p[30:0]};
          end else if (tys[ph] == TY_I32) begin
            x = 32'd0 - sb.int_scale() * y;
          end
        end
        send_elem(x, y, 1'($urandom_range(1)));
      end
      calm = 1'b0;
    end
    elem.valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_sums.size() != 0) @(posedge clk);
    repeat (NSTAGE + 3) @(posedge clk);
    if (sb.errors == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  initial begin
    #4_000_000;
    $display("Mismatches found");
    $finish;
  end
endmodule

>>> filelist.f
+incdir+sv
sv/sea_pkg.sv
sv/sea_in_if.sv
sv/sea_out_if.sv
sv/sea_cfg_if.sv
sv/sea_norm_round.sv
sv/scaled_elementwise_add_core.sv
tb/testbench.sv
